### sv/mrrt_pkg.sv
// shared types, constants and tables for the multi-reader ring topic block
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package mrrt_pkg;

    // fixed field widths
    localparam int DATA_W   = 64;
    localparam int GEN_W    = 32;
    localparam int LOST_W   = 32;
    localparam int QSIZE_W  = 5;
    localparam int FUNC_W   = 3;
    localparam int SUBIN_W  = 3;

    // parameter defaults
    localparam int QUEUE_DEPTH_DEF      = 16;
    localparam int SUBSCRIBER_SLOTS_DEF = 8;
    localparam int WORD_BITS_DEF        = 64;

    // request function codes
    typedef enum logic [FUNC_W-1:0] {
        FN_PUBLISH   = 3'd0,
        FN_SUBSCRIBE = 3'd1,
        FN_READ      = 3'd2,
        FN_CHECK     = 3'd3,
        FN_TAKE_LOST = 3'd4
    } t_func;

    // controller sequence
    typedef enum logic [1:0] {
        S_IDLE,
        S_LAG,
        S_CALC,
        S_OUT
    } t_state;

    // one result item
    typedef struct packed {
        logic              status;
        logic [DATA_W-1:0] read_data;
        logic              updated;
        logic [LOST_W-1:0] lost_count;
        logic [GEN_W-1:0]  generation;
    } t_result;

    // 2^32 mod q for every queue size code
    typedef logic [(1 << QSIZE_W)-1:0][QSIZE_W-1:0] t_mod_table;

    function automatic t_mod_table build_wrap_mod();
        t_mod_table tbl;
        logic [QSIZE_W:0] r;
        tbl = '0;
        for (int q = 1; q < (1 << QSIZE_W); q++) begin
            r = (q == 1) ? '0 : (QSIZE_W + 1)'(1);
            for (int b = 0; b < GEN_W; b++) begin
                r = r << 1;
                if (r >= (QSIZE_W + 1)'(q)) begin
                    r = r - (QSIZE_W + 1)'(q);
                end
            end
            tbl[q] = r[QSIZE_W-1:0];
        end
        return tbl;
    endfunction

    localparam t_mod_table WRAP_MOD = build_wrap_mod();

endpackage

### sv/mrrt_ring_mem.sv
// message ring storage: one write port, one registered read port
// uses mrrt_pkg only for consistency of the import style
`timescale 1ns / 1ps

module mrrt_ring_mem #(
    parameter int DEPTH  = 16,
    parameter int WIDTH  = 64,
    parameter int ADDR_W = 4
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);
    import mrrt_pkg::*;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/mrrt_gen_mem.sv
// reader generation storage with per-entry valid bits (unwritten reads zero)
// uses mrrt_pkg for the generation width
`timescale 1ns / 1ps

module mrrt_gen_mem #(
    parameter int SLOTS  = 8,
    parameter int ADDR_W = 3
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_we,
    input  logic [ADDR_W-1:0]          i_waddr,
    input  logic [mrrt_pkg::GEN_W-1:0] i_wdata,
    input  logic                       i_re,
    input  logic [ADDR_W-1:0]          i_raddr,
    output logic [mrrt_pkg::GEN_W-1:0] o_rdata
);
    import mrrt_pkg::*;

    logic [GEN_W-1:0] r_mem [SLOTS];
    logic [SLOTS-1:0] r_valid;
    logic [GEN_W-1:0] r_rdata;
    logic             r_rd_valid;

    // storage array and read data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    // valid bits, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_rd_valid <= r_valid[i_raddr] && !(i_we && i_waddr == i_raddr && 1'b0);
            end
        end
    end

    assign o_rdata = r_rd_valid ? r_rdata : '0;

endmodule

### sv/mrrt_ctrl.sv
// request sequencer: generation fetch, lag and slot arithmetic, state update
// uses mrrt_pkg; drives mrrt_ring_mem and mrrt_gen_mem
`timescale 1ns / 1ps

module mrrt_ctrl #(
    parameter int QUEUE_DEPTH      = mrrt_pkg::QUEUE_DEPTH_DEF,
    parameter int SUBSCRIBER_SLOTS = mrrt_pkg::SUBSCRIBER_SLOTS_DEF,
    parameter int WORD_BITS        = mrrt_pkg::WORD_BITS_DEF,
    parameter int SLOT_W           = 4,
    parameter int SUB_W            = 3
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // queue size register
    input  logic                         i_cfg_wen,
    input  logic [mrrt_pkg::QSIZE_W-1:0] i_cfg_wdata,
    // request side
    input  logic                         i_req_valid,
    output logic                         o_req_ready,
    input  logic [mrrt_pkg::FUNC_W-1:0]  i_func,
    input  logic [mrrt_pkg::SUBIN_W-1:0] i_sub,
    input  logic [mrrt_pkg::DATA_W-1:0]  i_data,
    // result side
    output logic                         o_res_valid,
    input  logic                         i_res_ready,
    output mrrt_pkg::t_result            o_res,
    // ring memory
    output logic                         o_ring_we,
    output logic [SLOT_W-1:0]            o_ring_waddr,
    output logic [WORD_BITS-1:0]         o_ring_wdata,
    output logic                         o_ring_re,
    output logic [SLOT_W-1:0]            o_ring_raddr,
    input  logic [WORD_BITS-1:0]         i_ring_rdata,
    // reader generation memory
    output logic                         o_gen_we,
    output logic [SUB_W-1:0]             o_gen_waddr,
    output logic [mrrt_pkg::GEN_W-1:0]   o_gen_wdata,
    output logic                         o_gen_re,
    output logic [SUB_W-1:0]             o_gen_raddr,
    input  logic [mrrt_pkg::GEN_W-1:0]   i_gen_rdata
);
    import mrrt_pkg::*;

    localparam int SUM_W = 9;
    localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(QUEUE_DEPTH);

    // subscriber index modulo the slot count, narrow repeated subtract
    function automatic logic [SUB_W-1:0] sub_index(input logic [SUBIN_W-1:0] s);
        logic [6:0] v;
        v = 7'(s);
        for (int k = 0; k < (1 << SUBIN_W); k++) begin
            if (v >= 7'(SUBSCRIBER_SLOTS)) begin
                v = v - 7'(SUBSCRIBER_SLOTS);
            end
        end
        return v[SUB_W-1:0];
    endfunction

    // control state
    t_state              r_state, n_state;
    logic [QSIZE_W-1:0]  r_qsize, n_qsize;
    logic                r_has_data, n_has_data;
    logic [GEN_W-1:0]    r_pub_gen, n_pub_gen;
    logic [SLOT_W-1:0]   r_pub_slot, n_pub_slot;
    logic [LOST_W-1:0]   r_lost, n_lost;

    // request payload and working values
    t_func               r_func, n_func;
    logic [SUB_W-1:0]    r_sub, n_sub;
    logic [WORD_BITS-1:0] r_data, n_data;
    logic [GEN_W-1:0]    r_rg, n_rg;
    logic [GEN_W-1:0]    r_lag, n_lag;
    logic                r_read_ok, n_read_ok;
    logic                r_res_status, n_res_status;
    logic                r_res_upd, n_res_upd;
    logic [LOST_W-1:0]   r_res_lost, n_res_lost;
    logic [GEN_W-1:0]    r_res_gen, n_res_gen;

    // read arithmetic
    logic                overrun;
    logic [QSIZE_W-1:0]  rd_back;
    logic                wraps;
    logic [SUM_W-1:0]    slot_sum, slot_n1, slot_n2;
    logic [QSIZE_W-1:0]  cfg_sat;

    // read distance from the publish generation and the slot it maps to
    always_comb begin
        overrun = r_lag > GEN_W'(r_qsize);
        if (overrun) begin
            rd_back = r_qsize;
        end else if (r_lag == '0) begin
            rd_back = QSIZE_W'(1);
        end else begin
            rd_back = r_lag[QSIZE_W-1:0];
        end
        wraps    = r_pub_gen < GEN_W'(rd_back);
        slot_sum = SUM_W'(r_pub_slot) + SUM_W'(r_qsize)
                 + (wraps ? SUM_W'(WRAP_MOD[r_qsize]) : '0) - SUM_W'(rd_back);
        slot_n1  = (slot_sum >= SUM_W'(r_qsize)) ? slot_sum - SUM_W'(r_qsize) : slot_sum;
        slot_n2  = (slot_n1 >= SUM_W'(r_qsize)) ? slot_n1 - SUM_W'(r_qsize) : slot_n1;
        cfg_sat  = (SUM_W'(i_cfg_wdata) > DEPTH_S) ? QSIZE_W'(QUEUE_DEPTH) : i_cfg_wdata;
    end

    // next state, memory accesses and results
    always_comb begin
        n_state      = r_state;
        n_qsize      = r_qsize;
        n_has_data   = r_has_data;
        n_pub_gen    = r_pub_gen;
        n_pub_slot   = r_pub_slot;
        n_lost       = r_lost;
        n_func       = r_func;
        n_sub        = r_sub;
        n_data       = r_data;
        n_rg         = r_rg;
        n_lag        = r_lag;
        n_read_ok    = r_read_ok;
        n_res_status = r_res_status;
        n_res_upd    = r_res_upd;
        n_res_lost   = r_res_lost;
        n_res_gen    = r_res_gen;

        o_req_ready  = 1'b0;
        o_res_valid  = 1'b0;
        o_ring_we    = 1'b0;
        o_ring_waddr = r_pub_slot;
        o_ring_wdata = r_data;
        o_ring_re    = 1'b0;
        o_ring_raddr = slot_n2[SLOT_W-1:0];
        o_gen_we     = 1'b0;
        o_gen_waddr  = r_sub;
        o_gen_wdata  = r_pub_gen;
        o_gen_re     = 1'b0;
        o_gen_raddr  = sub_index(i_sub);

        // queue size register: saturated to the depth, never shrinks, frozen once data exists
        if (i_cfg_wen && !r_has_data && cfg_sat >= r_qsize) begin
            n_qsize = cfg_sat;
        end

        unique case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_gen_re = 1'b1;
                    n_func   = t_func'(i_func);
                    n_sub    = sub_index(i_sub);
                    n_data   = i_data[WORD_BITS-1:0];
                    n_state  = S_LAG;
                end
            end
            S_LAG: begin
                n_rg    = i_gen_rdata;
                n_lag   = r_pub_gen - i_gen_rdata;
                n_state = S_CALC;
            end
            S_CALC: begin
                n_res_status = 1'b0;
                n_res_upd    = 1'b0;
                n_read_ok    = 1'b0;
                n_res_lost   = r_lost;
                case (r_func)
                    FN_PUBLISH: begin
                        o_ring_we  = 1'b1;
                        n_pub_gen  = r_pub_gen + GEN_W'(1);
                        n_has_data = 1'b1;
                        if (r_pub_gen == '1
                            || SUM_W'(r_pub_slot) + SUM_W'(1) == SUM_W'(r_qsize)) begin
                            n_pub_slot = '0;
                        end else begin
                            n_pub_slot = r_pub_slot + SLOT_W'(1);
                        end
                    end
                    FN_SUBSCRIBE: begin
                        o_gen_we = 1'b1;
                    end
                    FN_READ: begin
                        if (!r_has_data) begin
                            n_res_status = 1'b1;
                        end else begin
                            if (overrun) begin
                                n_lost = r_lost + (r_lag - GEN_W'(r_qsize));
                            end
                            o_ring_re   = 1'b1;
                            o_gen_we    = 1'b1;
                            o_gen_wdata = r_pub_gen - GEN_W'(rd_back) + GEN_W'(1);
                            n_read_ok   = 1'b1;
                        end
                        n_res_lost = n_lost;
                    end
                    FN_CHECK: begin
                        n_res_upd = r_has_data && (r_rg != r_pub_gen);
                    end
                    FN_TAKE_LOST: begin
                        n_lost = '0;
                    end
                    default: begin
                    end
                endcase
                n_res_gen = n_pub_gen;
                n_state   = S_OUT;
            end
            S_OUT: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_qsize    <= QSIZE_W'(1);
            r_has_data <= 1'b0;
            r_pub_gen  <= '0;
            r_pub_slot <= '0;
            r_lost     <= '0;
        end else begin
            r_state    <= n_state;
            r_qsize    <= n_qsize;
            r_has_data <= n_has_data;
            r_pub_gen  <= n_pub_gen;
            r_pub_slot <= n_pub_slot;
            r_lost     <= n_lost;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_func       <= n_func;
        r_sub        <= n_sub;
        r_data       <= n_data;
        r_rg         <= n_rg;
        r_lag        <= n_lag;
        r_read_ok    <= n_read_ok;
        r_res_status <= n_res_status;
        r_res_upd    <= n_res_upd;
        r_res_lost   <= n_res_lost;
        r_res_gen    <= n_res_gen;
    end

    // result word, ring data arrives in the cycle after the read
    always_comb begin
        o_res.status     = r_res_status;
        o_res.read_data  = r_read_ok ? DATA_W'(i_ring_rdata) : '0;
        o_res.updated    = r_res_upd;
        o_res.lost_count = r_res_lost;
        o_res.generation = r_res_gen;
    end

    // publish slot always inside the active ring
    a_pub_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        SUM_W'(r_pub_slot) < SUM_W'(r_qsize))
        else $error("publish slot outside active ring");

    // ring reads only hit active slots
    a_read_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ring_re |-> SUM_W'(o_ring_raddr) < SUM_W'(r_qsize))
        else $error("ring read outside active ring");

    // queue size is frozen once something was published
    a_qsize_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_has_data |=> $stable(r_qsize))
        else $error("queue size changed after publish");

    // a publish advances the generation by exactly one
    a_pub_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CALC && r_func == FN_PUBLISH)
            |=> r_pub_gen == $past(r_pub_gen) + GEN_W'(1))
        else $error("publish generation did not step");

    // reader generations only change on subscribe or a read with data
    a_gen_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_gen_we |-> (r_state == S_CALC
            && (r_func == FN_SUBSCRIBE || (r_func == FN_READ && r_has_data))))
        else $error("unexpected reader generation write");

endmodule

### sv/multi_reader_ring_topic_top.sv
// top level of the multi-reader ring topic: stream ports and result register
// uses mrrt_pkg, mrrt_ring_mem, mrrt_gen_mem and mrrt_ctrl
`timescale 1ns / 1ps

// One publisher, several subscribers sharing a ring of message words.
// Requests arrive on the s_axis channel: tdata carries the word to publish,
// tuser the function code and the subscriber slot. Every request yields one
// result on the m_axis channel: tuser is the status flag (set when a read
// finds nothing published), tdata packs read data, the updated flag, the
// lost counter and the publish generation.
// A request is taken, its subscriber generation fetched from the generation
// memory, the lag and ring slot worked out and the state written back, and
// the result loaded into the output register. tready is low while a request
// is in flight. A stalled receiver holds the output register; one more
// request can be worked up to its result while it waits, then the input side
// stalls. Reset clears generations, lost counter and the queue size (back to
// 1); ring contents are left as they are. The user must make queue size
// writes on the config port only while idle; the block does not enforce
// this. Writes are ignored once the first publish is done.
module multi_reader_ring_topic_top #(
    parameter int QUEUE_DEPTH      = mrrt_pkg::QUEUE_DEPTH_DEF,
    parameter int SUBSCRIBER_SLOTS = mrrt_pkg::SUBSCRIBER_SLOTS_DEF,
    parameter int WORD_BITS        = mrrt_pkg::WORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // queue size register
    input  logic                         i_cfg_wen,
    input  logic [mrrt_pkg::QSIZE_W-1:0] i_cfg_wdata,
    // request stream
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    input  logic [63:0]                  i_s_axis_tdata,  // data[63:0]
    input  logic [5:0]                   i_s_axis_tuser,  // func[2:0], subscriber[5:3]
    // result stream
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    // read_data[63:0], updated[64], lost_count[96:65], generation[128:97], zero pad
    output logic [135:0]                 o_m_axis_tdata,
    output logic [0:0]                   o_m_axis_tuser   // status[0]
);
    import mrrt_pkg::*;

    localparam int SLOT_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int SUB_W  = (SUBSCRIBER_SLOTS > 1) ? $clog2(SUBSCRIBER_SLOTS) : 1;

    logic                 res_valid;
    logic                 res_ready;
    t_result              res;
    logic                 ring_we, ring_re;
    logic [SLOT_W-1:0]    ring_waddr, ring_raddr;
    logic [WORD_BITS-1:0] ring_wdata, ring_rdata;
    logic                 gen_we, gen_re;
    logic [SUB_W-1:0]     gen_waddr, gen_raddr;
    logic [GEN_W-1:0]     gen_wdata, gen_rdata;

    logic                 r_out_valid;
    t_result              r_out;

    // request sequencer
    mrrt_ctrl #(
        .QUEUE_DEPTH      (QUEUE_DEPTH),
        .SUBSCRIBER_SLOTS (SUBSCRIBER_SLOTS),
        .WORD_BITS        (WORD_BITS),
        .SLOT_W           (SLOT_W),
        .SUB_W            (SUB_W)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wen    (i_cfg_wen),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_req_valid  (i_s_axis_tvalid),
        .o_req_ready  (o_s_axis_tready),
        .i_func       (i_s_axis_tuser[2:0]),
        .i_sub        (i_s_axis_tuser[5:3]),
        .i_data       (i_s_axis_tdata),
        .o_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .o_res        (res),
        .o_ring_we    (ring_we),
        .o_ring_waddr (ring_waddr),
        .o_ring_wdata (ring_wdata),
        .o_ring_re    (ring_re),
        .o_ring_raddr (ring_raddr),
        .i_ring_rdata (ring_rdata),
        .o_gen_we     (gen_we),
        .o_gen_waddr  (gen_waddr),
        .o_gen_wdata  (gen_wdata),
        .o_gen_re     (gen_re),
        .o_gen_raddr  (gen_raddr),
        .i_gen_rdata  (gen_rdata)
    );

    // message ring
    mrrt_ring_mem #(
        .DEPTH  (QUEUE_DEPTH),
        .WIDTH  (WORD_BITS),
        .ADDR_W (SLOT_W)
    ) u_ring_mem (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (ring_waddr),
        .i_wdata (ring_wdata),
        .i_re    (ring_re),
        .i_raddr (ring_raddr),
        .o_rdata (ring_rdata)
    );

    // subscriber generations
    mrrt_gen_mem #(
        .SLOTS  (SUBSCRIBER_SLOTS),
        .ADDR_W (SUB_W)
    ) u_gen_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (gen_we),
        .i_waddr (gen_waddr),
        .i_wdata (gen_wdata),
        .i_re    (gen_re),
        .i_raddr (gen_raddr),
        .o_rdata (gen_rdata)
    );

    // output register between sequencer and receiver
    assign res_ready = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    // pack result fields
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out.status;
    assign o_m_axis_tdata  = {7'd0, r_out.generation, r_out.lost_count,
                              r_out.updated, r_out.read_data};

endmodule

### tb/topic_result_checker.sv
// result checker for the multi-reader ring topic: tracks the topic state, predicts
// each result and compares it with what the block returns on the result stream
// depends on mrrt_pkg
`timescale 1ns / 1ps

module topic_result_checker
    import mrrt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wen,
    input  logic [QSIZE_W-1:0]   i_cfg_wdata,
    input  logic                 i_s_axis_tvalid,
    input  logic                 i_s_axis_tready,
    input  logic [63:0]          i_s_axis_tdata,  // data[63:0]
    input  logic [5:0]           i_s_axis_tuser,  // func[2:0], subscriber[5:3]
    input  logic                 i_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // read_data[63:0], updated[64], lost_count[96:65], generation[128:97], zero pad
    input  logic [135:0]         i_m_axis_tdata,
    input  logic [0:0]           i_m_axis_tuser,  // status[0]
    output int                   o_mismatches,
    output int                   o_outstanding
);

    // shadow copy of the topic state
    logic [DATA_W-1:0]  ring_words [QUEUE_DEPTH_DEF];
    logic [GEN_W-1:0]   pub_gen;
    logic [GEN_W-1:0]   reader_pos [SUBSCRIBER_SLOTS_DEF];
    logic [LOST_W-1:0]  lost_acc;
    logic               published;
    logic [QSIZE_W-1:0] ring_size;

    t_result due_results [$];
    int      mismatches  = 0;
    int      outstanding = 0;

    assign o_mismatches  = mismatches;
    assign o_outstanding = outstanding;

    // apply one request to the shadow state and return the result it should give
    function automatic t_result predict_request(input logic [FUNC_W-1:0] fn,
                                                input logic [SUBIN_W-1:0] sb,
                                                input logic [DATA_W-1:0] word);
        t_result          res;
        logic [GEN_W-1:0] pos;
        logic [GEN_W-1:0] lag;
        res = '0;
        case (fn)
            FN_PUBLISH: begin
                ring_words[pub_gen % GEN_W'(ring_size)] = word;
                pub_gen   = pub_gen + 1'b1;
                published = 1'b1;
            end
            FN_SUBSCRIBE: begin
                reader_pos[sb] = pub_gen;
            end
            FN_READ: begin
                if (!published) begin
                    res.status = 1'b1;
                end else begin
                    pos = reader_pos[sb];
                    lag = pub_gen - pos;
                    // reader fell off the ring: skip ahead and count the loss
                    if (lag > GEN_W'(ring_size)) begin
                        lost_acc = lost_acc + (lag - GEN_W'(ring_size));
                        pos      = pub_gen - GEN_W'(ring_size);
                    end
                    // reader already current: serve the newest word again
                    if (pos == pub_gen) begin
                        pos = pos - 1'b1;
                    end
                    res.read_data  = ring_words[pos % GEN_W'(ring_size)];
                    reader_pos[sb] = pos + 1'b1;
                end
            end
            FN_CHECK: begin
                res.updated = published && (reader_pos[sb] != pub_gen);
            end
            default: ;
        endcase
        res.lost_count = lost_acc;
        res.generation = pub_gen;
        if (fn == FN_TAKE_LOST) begin
            lost_acc = '0;
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_result              got;
        t_result              want;
        logic [QSIZE_W-1:0]   new_size;
        if (!i_rst_n) begin
            pub_gen    = '0;
            lost_acc   = '0;
            published  = 1'b0;
            ring_size  = QSIZE_W'(1);
            reader_pos = '{default: '0};
            due_results.delete();
        end else begin
            // queue size write: saturates, never shrinks, frozen after first publish
            if (i_cfg_wen) begin
                new_size = i_cfg_wdata;
                if (new_size > QSIZE_W'(QUEUE_DEPTH_DEF)) begin
                    new_size = QSIZE_W'(QUEUE_DEPTH_DEF);
                end
                if (!published && new_size >= ring_size) begin
                    ring_size = new_size;
                end
            end

            // compare each returned result with the oldest prediction
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got.status     = i_m_axis_tuser[0];
                got.read_data  = i_m_axis_tdata[63:0];
                got.updated    = i_m_axis_tdata[64];
                got.lost_count = i_m_axis_tdata[96:65];
                got.generation = i_m_axis_tdata[128:97];
                if (due_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%t: result with nothing outstanding: st=%0d data=%h upd=%0d lost=%0d gen=%0d",
                                 $realtime, got.status, got.read_data, got.updated,
                                 got.lost_count, got.generation);
                    end
                end else begin
                    want = due_results.pop_front();
                    if (got.status !== want.status || got.read_data !== want.read_data ||
                        got.updated !== want.updated || got.lost_count !== want.lost_count ||
                        got.generation !== want.generation) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%t: mismatch exp st=%0d data=%h upd=%0d lost=%0d gen=%0d",
                                     $realtime, want.status, want.read_data, want.updated,
                                     want.lost_count, want.generation);
                            $display("%t:          got st=%0d data=%h upd=%0d lost=%0d gen=%0d",
                                     $realtime, got.status, got.read_data, got.updated,
                                     got.lost_count, got.generation);
                        end
                    end
                end
            end

            // predict the result of each accepted request
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                due_results.push_back(predict_request(i_s_axis_tuser[2:0],
                                                      i_s_axis_tuser[5:3],
                                                      i_s_axis_tdata));
            end
            outstanding = due_results.size();
        end
    end

endmodule

### tb/tb_top.sv
// testbench top for the multi-reader ring topic: clock, reset, request stimulus,
// queue size writes, result stream back-pressure and the final verdict
// depends on mrrt_pkg, multi_reader_ring_topic_top and topic_result_checker
`timescale 1ns / 1ps

module tb_top;
    import mrrt_pkg::*;

    // function codes the block does not use
    localparam logic [FUNC_W-1:0] FN_SPARE_FIRST = 3'd5;
    localparam logic [FUNC_W-1:0] FN_SPARE_LAST  = 3'd7;
    localparam int RANDOM_REQUESTS = 1000;

    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    logic                 i_cfg_wen       = 1'b0;
    logic [QSIZE_W-1:0]   i_cfg_wdata     = '0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic [63:0]          i_s_axis_tdata  = '0;
    logic [5:0]           i_s_axis_tuser  = '0;
    logic                 i_m_axis_tready = 1'b0;
    logic                 o_s_axis_tready;
    logic                 o_m_axis_tvalid;
    logic [135:0]         o_m_axis_tdata;
    logic [0:0]           o_m_axis_tuser;

    int mismatches;
    int outstanding;
    int src_idle_pct = 21;
    int dst_idle_pct = 46;
    int ring_slots;

    always #6 i_clk = ~i_clk;

    multi_reader_ring_topic_top DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wen       (i_cfg_wen),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    topic_result_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wen       (i_cfg_wen),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .i_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_m_axis_tdata  (o_m_axis_tdata),
        .i_m_axis_tuser  (o_m_axis_tuser),
        .o_mismatches    (mismatches),
        .o_outstanding   (outstanding)
    );

    // random back-pressure on the result stream
    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(0, 99) >= dst_idle_pct);
    end

    // present one request, with a random gap first, and wait until it is taken
    task automatic send_req(input logic [FUNC_W-1:0] fn, input logic [SUBIN_W-1:0] sb,
                            input logic [DATA_W-1:0] word);
        i_cfg_wen <= 1'b0;
        if ($urandom_range(0, 99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < src_idle_pct);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= word;
        i_s_axis_tuser  <= {sb, fn};
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    // queue size write; enable stays high until the next request goes out
    task automatic write_ring_size(input logic [QSIZE_W-1:0] val);
        i_cfg_wen   <= 1'b1;
        i_cfg_wdata <= val;
        @(posedge i_clk);
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    initial begin
        logic [QSIZE_W-1:0]  final_size;
        logic [FUNC_W-1:0]   fn;
        logic [DATA_W-1:0]   word;
        int                  roll;
        int                  burst;
        int                  sent;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // before any publish: zero size ignored, reads find nothing, spare codes
        write_ring_size('0);
        write_ring_size(QSIZE_W'(1));
        send_req(FN_READ, 3'd0, {$urandom, $urandom});
        send_req(FN_CHECK, 3'd7, '0);
        send_req(FN_TAKE_LOST, 3'd2, '1);
        send_req(FN_SUBSCRIBE, 3'd3, '0);
        send_req(FN_SPARE_FIRST, 3'd4, '1);
        send_req(FN_SPARE_LAST, 3'd5, '0);
        drain_results();

        // grow the ring, then a smaller value that must be ignored
        write_ring_size(QSIZE_W'(6));
        write_ring_size(QSIZE_W'(3));
        send_req(FN_READ, 3'd7, '0);
        drain_results();

        // final size: sometimes the saturating maximum, mostly a small ring
        final_size = ($urandom_range(0, 2) == 0) ? '1 : QSIZE_W'($urandom_range(6, 12));
        ring_slots = (final_size > QUEUE_DEPTH_DEF) ? QUEUE_DEPTH_DEF : final_size;
        write_ring_size(final_size);

        // walk reader 0 through the first words, then re-read when current
        send_req(FN_PUBLISH, 3'd6, '1);
        send_req(FN_PUBLISH, 3'd1, '0);
        send_req(FN_PUBLISH, 3'd0, 64'hA5A5_5A5A_F00F_0FF0);
        repeat (4) send_req(FN_READ, 3'd0, '0);
        send_req(FN_CHECK, 3'd0, '0);
        send_req(FN_CHECK, 3'd1, '0);
        send_req(FN_SUBSCRIBE, 3'd1, '0);
        send_req(FN_CHECK, 3'd1, '0);
        send_req(FN_READ, 3'd1, '0);

        // lagging reader 2 gets pulled forward and the loss is counted
        repeat (ring_slots) send_req(FN_PUBLISH, 3'($urandom), {$urandom, $urandom});
        send_req(FN_READ, 3'd2, '0);
        send_req(FN_TAKE_LOST, 3'd2, '0);
        send_req(FN_TAKE_LOST, 3'd2, '0);
        drain_results();

        // writes after the first publish are ignored
        write_ring_size('1);
        write_ring_size(QSIZE_W'(2));

        // random mix, occasionally a publish burst long enough to overrun readers
        sent = 0;
        while (sent < RANDOM_REQUESTS) begin
            if (sent < RANDOM_REQUESTS / 3) begin
                src_idle_pct = 21;
                dst_idle_pct = 46;
            end else if (sent < 2 * RANDOM_REQUESTS / 3) begin
                src_idle_pct = 46;
                dst_idle_pct = 21;
            end else begin
                src_idle_pct = 0;
                dst_idle_pct = 0;
            end

            if ($urandom_range(0, 99) < 3) begin
                burst = ring_slots + $urandom_range(1, 8);
                repeat (burst) send_req(FN_PUBLISH, 3'($urandom), {$urandom, $urandom});
                sent += burst;
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 35) begin
                    fn = FN_PUBLISH;
                end else if (roll < 65) begin
                    fn = FN_READ;
                end else if (roll < 75) begin
                    fn = FN_CHECK;
                end else if (roll < 83) begin
                    fn = FN_SUBSCRIBE;
                end else if (roll < 93) begin
                    fn = FN_TAKE_LOST;
                end else begin
                    fn = FUNC_W'($urandom_range(FN_SPARE_FIRST, FN_SPARE_LAST));
                end
                case ($urandom_range(0, 15))
                    0:       word = '0;
                    1:       word = '1;
                    default: word = {$urandom, $urandom};
                endcase
                send_req(fn, 3'($urandom_range(0, SUBSCRIBER_SLOTS_DEF - 1)), word);
                sent++;
            end
        end

        drain_results();
        // keep the clock running to catch any stray result
        repeat (16) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

    // hang guard, far beyond the slowest correct run
    initial begin
        #3_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule
